// ----- src/segment_box_intersection_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the segment/box port checker.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_BOX_INTERSECTION_MACROS_SVH
`define SEGMENT_BOX_INTERSECTION_MACROS_SVH

// same-cycle implication
`define SBI_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SBI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/sbi_pkg.sv -----
// ----------------------------------------------------------------------------
// sbi_pkg
// Types, constants and helpers for the segment/box intersection block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbi_pkg;

   localparam int COORD_W       = 32;
   localparam int HALF_W        = 30;
   localparam int BOUND_W       = 34;
   localparam int MAG_W         = 33;
   localparam int OFF_W         = 32;
   localparam int DIST_W        = 64;
   localparam int NUM_AXES      = 3;
   localparam int NUM_FACES     = 6;
   localparam int FRAC_BITS_DEF = 16;
   localparam int QUEUE_DEPTH   = 4;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X,
      CSR_CENTER_Y,
      CSR_CENTER_Z,
      CSR_HALF_X,
      CSR_HALF_Y,
      CSR_HALF_Z
   } csr_idx_type;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [BOUND_W-1:0] bound_type;
   typedef logic signed [MAG_W-1:0]   diff_type;
   typedef logic        [MAG_W-1:0]   mag_type;

   typedef struct packed {
      bound_type [NUM_AXES-1:0] lo;
      bound_type [NUM_AXES-1:0] hi;
   } bounds_type;

   typedef struct packed {
      logic    cand;
      mag_type num;
      mag_type den;
   } face_job_type;

   typedef struct packed {
      coord_type    [NUM_AXES-1:0]  s;
      coord_type    [NUM_AXES-1:0]  e;
      logic                         in_box;
      face_job_type [NUM_FACES-1:0] face;
   } job_type;

   function automatic bound_type to_bound(coord_type c);
      return {{(BOUND_W-COORD_W){c[COORD_W-1]}}, c};
   endfunction

   function automatic diff_type to_diff(coord_type c);
      return {{(MAG_W-COORD_W){c[COORD_W-1]}}, c};
   endfunction

endpackage

`default_nettype wire

// ----- src/sbi_ifs.sv -----
// ----------------------------------------------------------------------------
// sbi_req_if / sbi_rsp_if
// Valid/ready channels carrying segments in and intersection results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sbi_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] start_x;
   logic signed [31:0] start_y;
   logic signed [31:0] start_z;
   logic signed [31:0] end_x;
   logic signed [31:0] end_y;
   logic signed [31:0] end_z;

   modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                   input ready);
   modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                   output ready);
endinterface

interface sbi_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;

   modport source (output valid, hit, point_x, point_y, point_z, input ready);
   modport sink   (input valid, hit, point_x, point_y, point_z, output ready);
endinterface

`default_nettype wire

// ----- src/sbi_front.sv -----
// ----------------------------------------------------------------------------
// sbi_front
// Accepts segments, classifies each face as a crossing candidate and builds
// the divider operands; one register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbi_front (
   input  logic                clock,
   input  logic                reset,
   sbi_req_if.sink             req,
   input  sbi_pkg::bounds_type bounds,
   output logic                job_valid,
   input  logic                job_ready,
   output sbi_pkg::job_type    job
);
   import sbi_pkg::*;

   coord_type [NUM_AXES-1:0] s_w;
   coord_type [NUM_AXES-1:0] e_w;
   diff_type                 d_w  [NUM_AXES];
   coord_type                mn_w [NUM_AXES];
   coord_type                mx_w [NUM_AXES];
   logic                     in_w [NUM_AXES];
   logic                     cand_w [NUM_FACES];
   mag_type                  num_w  [NUM_FACES];
   mag_type                  den_w  [NUM_FACES];
   job_type                  job_in;
   job_type                  job_ff;
   logic                     valid_ff;

   assign s_w = {req.start_z, req.start_y, req.start_x};
   assign e_w = {req.end_z, req.end_y, req.end_x};

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      assign d_w[a]  = to_diff(e_w[a]) - to_diff(s_w[a]);
      assign mn_w[a] = (s_w[a] < e_w[a]) ? s_w[a] : e_w[a];
      assign mx_w[a] = (s_w[a] < e_w[a]) ? e_w[a] : s_w[a];
      assign in_w[a] = (to_bound(s_w[a]) > $signed(bounds.lo[a])) &&
                       (to_bound(s_w[a]) < $signed(bounds.hi[a]));
   end

   for (genvar f = 0; f < NUM_FACES; f++) begin : g_face
      localparam int AX   = f / 2;
      localparam int SIDE = f % 2;
      bound_type                 face_v;
      logic signed [BOUND_W:0]   diff_v;
      logic        [BOUND_W:0]   abs_v;
      logic        [MAG_W-1:0]   dabs_v;

      assign face_v = (SIDE != 0) ? $signed(bounds.hi[AX]) : $signed(bounds.lo[AX]);
      assign diff_v = $signed({face_v[BOUND_W-1], face_v}) -
                      $signed({s_w[AX][COORD_W-1], to_bound(s_w[AX])});
      assign abs_v  = diff_v[BOUND_W] ? (BOUND_W+1)'(-diff_v) : (BOUND_W+1)'(diff_v);
      assign dabs_v = d_w[AX][MAG_W-1] ? MAG_W'(-d_w[AX]) : MAG_W'(d_w[AX]);
      assign num_w[f]  = abs_v[MAG_W-1:0];
      assign den_w[f]  = dabs_v;
      assign cand_w[f] = (d_w[AX] != '0) && (face_v >= to_bound(mn_w[AX])) &&
                         (face_v <= to_bound(mx_w[AX]));
   end

   always_comb begin
      job_in.s      = s_w;
      job_in.e      = e_w;
      job_in.in_box = in_w[0] && in_w[1] && in_w[2];
      for (int f = 0; f < NUM_FACES; f++) begin
         job_in.face[f].cand = cand_w[f];
         job_in.face[f].num  = num_w[f];
         job_in.face[f].den  = den_w[f];
      end
   end

   assign req.ready = !valid_ff || job_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req.ready) begin
         valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         job_ff <= job_in;
      end
   end

   assign job_valid = valid_ff;
   assign job       = job_ff;

endmodule

`default_nettype wire

// ----- src/sbi_fifo.sv -----
// ----------------------------------------------------------------------------
// sbi_fifo
// Short register queue decoupling the front classifier from the back pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbi_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  sbi_pkg::job_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output sbi_pkg::job_type out_data
);
   import sbi_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = count_ff != CNT_W'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

// ----- src/sbi_div.sv -----
// ----------------------------------------------------------------------------
// sbi_div
// Pipelined restoring divider, one quotient bit per stage, giving
// floor(num * 2^FRAC_BITS / den) for num <= den.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbi_div #(
   parameter int FRAC_BITS = sbi_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             en,
   input  sbi_pkg::mag_type num,
   input  sbi_pkg::mag_type den,
   output logic [FRAC_BITS:0] quo
);
   import sbi_pkg::*;

   localparam int STAGES = FRAC_BITS + 1;

   mag_type            rem_ff [STAGES];
   mag_type            den_ff [STAGES];
   logic [FRAC_BITS:0] q_ff   [STAGES];

   for (genvar j = 0; j < STAGES; j++) begin : g_stage
      logic [MAG_W:0]     trial;
      logic [MAG_W:0]     sub;
      mag_type            dv;
      logic [FRAC_BITS:0] qp;
      logic               ge;
      logic [FRAC_BITS:0] q_in;
      mag_type            rem_in;

      if (j == 0) begin : g_first
         assign trial = {1'b0, num};
         assign dv    = den;
         assign qp    = '0;
      end else begin : g_next
         assign trial = {rem_ff[j-1], 1'b0};
         assign dv    = den_ff[j-1];
         assign qp    = q_ff[j-1];
      end

      assign sub    = trial - {1'b0, dv};
      assign ge     = trial >= {1'b0, dv};
      assign rem_in = ge ? sub[MAG_W-1:0] : trial[MAG_W-1:0];

      always_comb begin
         q_in                  = qp;
         q_in[FRAC_BITS - j]   = ge;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            den_ff[j] <= dv;
            q_ff[j]   <= q_in;
         end
      end
   end

   assign quo = q_ff[STAGES-1];

endmodule

`default_nettype wire

// ----- src/sbi_back.sv -----
// ----------------------------------------------------------------------------
// sbi_back
// Back pipeline: six face dividers, crossing point, bounds check, squared
// distance, nearest-crossing reduction and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbi_back #(
   parameter int FRAC_BITS = sbi_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  sbi_pkg::bounds_type bounds,
   input  logic                job_valid,
   output logic                job_ready,
   input  sbi_pkg::job_type    job,
   sbi_rsp_if.source           rsp
);
   import sbi_pkg::*;

   localparam int STAGES = FRAC_BITS + 1;
   localparam int Q_W    = FRAC_BITS + 1;
   localparam int PROD_W = MAG_W + Q_W;
   localparam int TAIL   = 6;

   typedef struct packed {
      logic                     hit;
      logic [DIST_W-1:0]        dsq;
      coord_type [NUM_AXES-1:0] point;
   } cand_type;

   function automatic cand_type pick(cand_type a, cand_type b);
      return (b.hit && (!a.hit || (b.dsq < a.dsq))) ? b : a;
   endfunction

   logic              en;
   logic [Q_W-1:0]    quo      [NUM_FACES];
   logic              div_vld_ff [STAGES];
   job_type           div_job_ff [STAGES];
   logic              tl_vld_ff  [TAIL];
   job_type           tl_job_ff  [TAIL];

   logic [OFF_W-1:0]  off_in  [NUM_FACES][NUM_AXES];
   logic              neg_in  [NUM_FACES][NUM_AXES];
   logic [OFF_W-1:0]  off_ff  [NUM_FACES][NUM_AXES];
   logic              neg_ff  [NUM_FACES][NUM_AXES];

   logic              ok_w    [NUM_FACES][NUM_AXES];
   coord_type         pt_in   [NUM_FACES][NUM_AXES];
   logic [OFF_W-1:0]  mag_in  [NUM_FACES][NUM_AXES];
   logic              hit_in  [NUM_FACES];
   coord_type         v_pt_ff  [NUM_FACES][NUM_AXES];
   logic [OFF_W-1:0]  v_mag_ff [NUM_FACES][NUM_AXES];
   logic              v_hit_ff [NUM_FACES];

   coord_type         q_pt_ff  [NUM_FACES][NUM_AXES];
   logic [DIST_W-1:0] q_sq_ff  [NUM_FACES][NUM_AXES];
   logic              q_hit_ff [NUM_FACES];

   logic [DIST_W+1:0] sum_w    [NUM_FACES];
   cand_type          s_cand_ff [NUM_FACES];
   cand_type          c1_ff [3];
   cand_type          c2_ff [2];
   cand_type          best_w;

   logic              rsp_vld_ff;
   logic              rsp_hit_ff, rsp_hit_in;
   coord_type [NUM_AXES-1:0] rsp_pt_ff, rsp_pt_in;

   assign en        = !rsp_vld_ff || rsp.ready;
   assign job_ready = en;

   // divider stages
   for (genvar f = 0; f < NUM_FACES; f++) begin : g_div
      sbi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock (clock),
         .en    (en),
         .num   (job.face[f].num),
         .den   (job.face[f].den),
         .quo   (quo[f])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) div_vld_ff[i] <= 1'b0;
         for (int i = 0; i < TAIL; i++)   tl_vld_ff[i]  <= 1'b0;
      end else if (en) begin
         div_vld_ff[0] <= job_valid;
         for (int i = 1; i < STAGES; i++) div_vld_ff[i] <= div_vld_ff[i-1];
         tl_vld_ff[0] <= div_vld_ff[STAGES-1];
         for (int i = 1; i < TAIL; i++)   tl_vld_ff[i] <= tl_vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_job_ff[0] <= job;
         for (int i = 1; i < STAGES; i++) div_job_ff[i] <= div_job_ff[i-1];
         tl_job_ff[0] <= div_job_ff[STAGES-1];
         for (int i = 1; i < TAIL; i++)   tl_job_ff[i] <= tl_job_ff[i-1];
      end
   end

   // offsets along the other axes: (e - s) * t / 2^FRAC_BITS toward zero
   for (genvar f = 0; f < NUM_FACES; f++) begin : g_mul
      localparam int AX = f / 2;
      for (genvar k = 0; k < NUM_AXES; k++) begin : g_k
         if (k == AX) begin : g_on
            assign off_in[f][k] = '0;
            assign neg_in[f][k] = 1'b0;
         end else begin : g_off
            diff_type          dk;
            logic [MAG_W-1:0]  dmag;
            logic [PROD_W-1:0] prod;
            assign dk   = to_diff(div_job_ff[STAGES-1].e[k]) -
                          to_diff(div_job_ff[STAGES-1].s[k]);
            assign dmag = dk[MAG_W-1] ? MAG_W'(-dk) : MAG_W'(dk);
            assign prod = PROD_W'(dmag) * PROD_W'(quo[f]);
            assign off_in[f][k] = prod[FRAC_BITS +: OFF_W];
            assign neg_in[f][k] = dk[MAG_W-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         off_ff <= off_in;
         neg_ff <= neg_in;
      end
   end

   // crossing point and bounds checks
   for (genvar f = 0; f < NUM_FACES; f++) begin : g_pt
      localparam int AX   = f / 2;
      localparam int SIDE = f % 2;
      bound_type face_v;
      assign face_v = (SIDE != 0) ? $signed(bounds.hi[AX]) : $signed(bounds.lo[AX]);
      for (genvar k = 0; k < NUM_AXES; k++) begin : g_k
         if (k == AX) begin : g_on
            assign ok_w[f][k]   = 1'b1;
            assign pt_in[f][k]  = face_v[COORD_W-1:0];
            assign mag_in[f][k] = tl_job_ff[0].face[f].num[OFF_W-1:0];
         end else begin : g_off
            coord_type sk, ek, mn, mx;
            bound_type offv, v;
            assign sk   = tl_job_ff[0].s[k];
            assign ek   = tl_job_ff[0].e[k];
            assign mn   = (sk < ek) ? sk : ek;
            assign mx   = (sk < ek) ? ek : sk;
            assign offv = {{(BOUND_W-OFF_W){1'b0}}, off_ff[f][k]};
            assign v    = to_bound(sk) + (neg_ff[f][k] ? -offv : offv);
            assign ok_w[f][k] = (v >= $signed(bounds.lo[k])) &&
                                (v <= $signed(bounds.hi[k])) &&
                                (v >= to_bound(mn)) && (v <= to_bound(mx));
            assign pt_in[f][k]  = v[COORD_W-1:0];
            assign mag_in[f][k] = off_ff[f][k];
         end
      end
      assign hit_in[f] = tl_job_ff[0].face[f].cand && ok_w[f][0] && ok_w[f][1] &&
                         ok_w[f][2];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_pt_ff  <= pt_in;
         v_mag_ff <= mag_in;
         v_hit_ff <= hit_in;
      end
   end

   // squares
   always_ff @(posedge clock) begin
      if (en) begin
         for (int f = 0; f < NUM_FACES; f++) begin
            q_hit_ff[f] <= v_hit_ff[f];
            for (int k = 0; k < NUM_AXES; k++) begin
               q_pt_ff[f][k] <= v_pt_ff[f][k];
               q_sq_ff[f][k] <= DIST_W'(v_mag_ff[f][k]) * DIST_W'(v_mag_ff[f][k]);
            end
         end
      end
   end

   // saturating distance sum
   for (genvar f = 0; f < NUM_FACES; f++) begin : g_sum
      assign sum_w[f] = {2'b00, q_sq_ff[f][0]} + {2'b00, q_sq_ff[f][1]} +
                        {2'b00, q_sq_ff[f][2]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int f = 0; f < NUM_FACES; f++) begin
            s_cand_ff[f].hit  <= q_hit_ff[f];
            s_cand_ff[f].dsq  <= (sum_w[f][DIST_W+1:DIST_W] != 2'b00) ? '1 :
                                 sum_w[f][DIST_W-1:0];
            for (int k = 0; k < NUM_AXES; k++) begin
               s_cand_ff[f].point[k] <= q_pt_ff[f][k];
            end
         end
      end
   end

   // nearest crossing, earlier face wins ties
   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff[0] <= pick(s_cand_ff[0], s_cand_ff[1]);
         c1_ff[1] <= pick(s_cand_ff[2], s_cand_ff[3]);
         c1_ff[2] <= pick(s_cand_ff[4], s_cand_ff[5]);
         c2_ff[0] <= pick(c1_ff[0], c1_ff[1]);
         c2_ff[1] <= c1_ff[2];
      end
   end

   assign best_w = pick(c2_ff[0], c2_ff[1]);

   always_comb begin
      rsp_hit_in = best_w.hit || tl_job_ff[TAIL-1].in_box;
      for (int k = 0; k < NUM_AXES; k++) begin
         if (best_w.hit) begin
            rsp_pt_in[k] = best_w.point[k];
         end else if (tl_job_ff[TAIL-1].in_box) begin
            rsp_pt_in[k] = tl_job_ff[TAIL-1].s[k];
         end else begin
            rsp_pt_in[k] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= tl_vld_ff[TAIL-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_hit_ff <= rsp_hit_in;
         rsp_pt_ff  <= rsp_pt_in;
      end
   end

   assign rsp.valid   = rsp_vld_ff;
   assign rsp.hit     = rsp_hit_ff;
   assign rsp.point_x = rsp_pt_ff[0];
   assign rsp.point_y = rsp_pt_ff[1];
   assign rsp.point_z = rsp_pt_ff[2];

endmodule

`default_nettype wire

// ----- src/segment_box_intersection.sv -----
// ----------------------------------------------------------------------------
// segment_box_intersection
// Segment versus axis-aligned box test in signed fixed point, reporting a hit
// and the face crossing nearest the segment start, else the start if inside.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  req_ch   in   valid/ready   start_x/y/z, end_x/y/z
//  rsp_ch   out  valid/ready   hit, point_x/y/z
//  csr_*    in   csr_we        csr_index, csr_wdata
//
//  One transaction per cycle sustained while rsp_ch accepts results; the face
//  dividers are pipelined, one quotient bit per stage.
//  Reset clears the box registers and all valid flags; no clearing pass.
//  A stalled rsp_ch holds the back pipeline; the queue and front keep
//  taking transactions until the queue fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module segment_box_intersection #(
   parameter int FRAC_BITS = sbi_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   sbi_req_if.sink                          req_ch,
   sbi_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [sbi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sbi_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import sbi_pkg::*;

   coord_type [NUM_AXES-1:0]             center_ff;
   logic      [NUM_AXES-1:0][HALF_W-1:0] half_ff;
   bounds_type                           bounds_w;
   logic                                 fr_valid, fr_ready;
   job_type                              fr_job;
   logic                                 bk_valid, bk_ready;
   job_type                              bk_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         half_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_CENTER_X: center_ff[0] <= csr_wdata[COORD_W-1:0];
            CSR_CENTER_Y: center_ff[1] <= csr_wdata[COORD_W-1:0];
            CSR_CENTER_Z: center_ff[2] <= csr_wdata[COORD_W-1:0];
            CSR_HALF_X:   half_ff[0]   <= csr_wdata[HALF_W-1:0];
            CSR_HALF_Y:   half_ff[1]   <= csr_wdata[HALF_W-1:0];
            CSR_HALF_Z:   half_ff[2]   <= csr_wdata[HALF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         bounds_w.lo[k] = to_bound(center_ff[k]) -
                          $signed({{(BOUND_W-HALF_W){1'b0}}, half_ff[k]});
         bounds_w.hi[k] = to_bound(center_ff[k]) +
                          $signed({{(BOUND_W-HALF_W){1'b0}}, half_ff[k]});
      end
   end

   sbi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .bounds    (bounds_w),
      .job_valid (fr_valid),
      .job_ready (fr_ready),
      .job       (fr_job)
   );

   sbi_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_data   (fr_job),
      .out_valid (bk_valid),
      .out_ready (bk_ready),
      .out_data  (bk_job)
   );

   sbi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .bounds    (bounds_w),
      .job_valid (bk_valid),
      .job_ready (bk_ready),
      .job       (bk_job),
      .rsp       (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- src/sbi_checker.sv -----
// ----------------------------------------------------------------------------
// sbi_checker
// Port-level checks for the segment/box block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "segment_box_intersection_macros.svh"

module sbi_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_hit,
   input logic signed [31:0] rsp_point_x,
   input logic signed [31:0] rsp_point_y,
   input logic signed [31:0] rsp_point_z
);
   localparam int PEND_W = 8;

   logic [PEND_W-1:0] pending_ff, pending_in;

   assign pending_in = pending_ff + PEND_W'(req_valid && req_ready) -
                       PEND_W'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `SBI_ASSERT_IMPLIES(a_miss_zero, clock, reset, rsp_valid && !rsp_hit, rsp_point_x == 32'sd0 && rsp_point_y == 32'sd0 && rsp_point_z == 32'sd0, "miss with nonzero point")
   `SBI_ASSERT_IMPLIES(a_no_orphan, clock, reset, rsp_valid, pending_ff != '0, "result without transaction")
   `SBI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hit) && $stable(rsp_point_x), "stalled result changed")

endmodule

bind segment_box_intersection sbi_checker u_sbi_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_hit     (rsp_ch.hit),
   .rsp_point_x (rsp_ch.point_x),
   .rsp_point_y (rsp_ch.point_y),
   .rsp_point_z (rsp_ch.point_z)
);

`default_nettype wire

// ----- tb/sbi_result_checker.sv -----
// ----------------------------------------------------------------------------
// sbi_result_checker
// Watches the segment and result channels and the register port, predicts the
// hit flag and nearest crossing for every accepted segment, and compares each
// result transaction in order against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbi_result_checker
   import sbi_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   sbi_req_if                    req,
   sbi_rsp_if                    rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    pending,
   output int                    checked,
   output int                    hits
);

   typedef struct {
      logic      hit;
      coord_type px;
      coord_type py;
      coord_type pz;
   } crossing_type;

   localparam longint ONE = longint'(1) << FRAC_BITS;

   longint       box_center [3];
   longint       box_half   [3];
   crossing_type expected_q [$];

   function automatic longint lo_of(longint a, longint b);
      return (a < b) ? a : b;
   endfunction

   function automatic longint hi_of(longint a, longint b);
      return (a > b) ? a : b;
   endfunction

   function automatic crossing_type nearest_crossing(longint s [3], longint e [3]);
      longint            bmn [3];
      longint            bmx [3];
      longint            pt  [3];
      longint            best [3];
      longint            face, d, t, v, df;
      longint unsigned   dsq, best_dist, mag, sq;
      logic              found, in_box, ok;
      crossing_type      r;
      found     = 1'b0;
      in_box    = 1'b1;
      best_dist = 0;
      for (int k = 0; k < 3; k++) begin
         bmn[k]  = box_center[k] - box_half[k];
         bmx[k]  = box_center[k] + box_half[k];
         best[k] = 0;
         pt[k]   = 0;
         if (!(s[k] > bmn[k] && s[k] < bmx[k])) in_box = 1'b0;
      end
      for (int a = 0; a < 3; a++) begin
         for (int side = 0; side < 2; side++) begin
            face = side ? bmx[a] : bmn[a];
            d    = e[a] - s[a];
            ok   = 1'b1;
            if (d == 0) ok = 1'b0;
            else if (face < lo_of(s[a], e[a]) || face > hi_of(s[a], e[a])) ok = 1'b0;
            if (ok) begin
               t = ((face - s[a]) * ONE) / d;
               if (t < 0) t = 0;
               if (t > ONE) t = ONE;
               for (int k = 0; k < 3; k++) begin
                  if (k != a && ok) begin
                     v = s[k] + ((e[k] - s[k]) * t) / ONE;
                     if (v < bmn[k] || v > bmx[k]) ok = 1'b0;
                     if (v < lo_of(s[k], e[k]) || v > hi_of(s[k], e[k])) ok = 1'b0;
                     pt[k] = v;
                  end
               end
               pt[a] = face;
            end
            if (ok) begin
               dsq = 0;
               for (int k = 0; k < 3; k++) begin
                  df  = pt[k] - s[k];
                  mag = (df < 0) ? longint'(-df) : longint'(df);
                  sq  = mag * mag;
                  if (dsq > 64'hFFFF_FFFF_FFFF_FFFF - sq) dsq = 64'hFFFF_FFFF_FFFF_FFFF;
                  else dsq = dsq + sq;
               end
               if (!found || dsq < best_dist) begin
                  best_dist = dsq;
                  for (int k = 0; k < 3; k++) best[k] = pt[k];
               end
               found = 1'b1;
            end
         end
      end
      if (!found && in_box)
         for (int k = 0; k < 3; k++) best[k] = s[k];
      r.hit = found || in_box;
      r.px  = r.hit ? coord_type'(best[0]) : '0;
      r.py  = r.hit ? coord_type'(best[1]) : '0;
      r.pz  = r.hit ? coord_type'(best[2]) : '0;
      return r;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   initial begin
      mismatches = 0;
      pending    = 0;
      checked    = 0;
      hits       = 0;
      for (int k = 0; k < 3; k++) begin
         box_center[k] = 0;
         box_half[k]   = 0;
      end
   end

   always @(posedge clock) begin
      longint       s [3];
      longint       e [3];
      crossing_type want;
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            box_center[k] = 0;
            box_half[k]   = 0;
         end
      end else begin
         if (csr_we) begin
            case (csr_idx_type'(csr_index))
               CSR_CENTER_X: box_center[0] = longint'(signed'(csr_wdata));
               CSR_CENTER_Y: box_center[1] = longint'(signed'(csr_wdata));
               CSR_CENTER_Z: box_center[2] = longint'(signed'(csr_wdata));
               CSR_HALF_X:   box_half[0]   = longint'(csr_wdata[HALF_W-1:0]);
               CSR_HALF_Y:   box_half[1]   = longint'(csr_wdata[HALF_W-1:0]);
               CSR_HALF_Z:   box_half[2]   = longint'(csr_wdata[HALF_W-1:0]);
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
               report("unexpected transaction", rsp.hit, 0);
            end else begin
               want = expected_q.pop_front();
               checked++;
               if (want.hit) hits++;
               if (rsp.hit !== want.hit) report("hit", rsp.hit, want.hit);
               if (rsp.point_x !== want.px) report("point_x", rsp.point_x, want.px);
               if (rsp.point_y !== want.py) report("point_y", rsp.point_y, want.py);
               if (rsp.point_z !== want.pz) report("point_z", rsp.point_z, want.pz);
            end
         end
         if (req.valid && req.ready) begin
            s[0] = req.start_x; s[1] = req.start_y; s[2] = req.start_z;
            e[0] = req.end_x;   e[1] = req.end_y;   e[2] = req.end_z;
            expected_q.push_back(nearest_crossing(s, e));
         end
      end
      pending = expected_q.size();
   end

endmodule

// ----- tb/tb_segment_box_intersection.sv -----
// ----------------------------------------------------------------------------
// tb_segment_box_intersection
// Drives segments through the intersection block under several box settings,
// with random idling on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_segment_box_intersection;
   import sbi_pkg::*;

   localparam int     FRAC = FRAC_BITS_DEF;
   localparam longint ONE  = longint'(1) << FRAC;
   localparam int     DRAIN_CYCLES = FRAC + 24;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  quiet = 1'b0;
   int                    mismatches, pending, checked, hits;
   longint                box_c [3];
   longint                box_h [3];

   sbi_req_if req_ch ();
   sbi_rsp_if rsp_ch ();

   segment_box_intersection #(.FRAC_BITS(FRAC)) u_top (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   sbi_result_checker #(.FRAC_BITS(FRAC)) u_checker (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatches(mismatches), .pending(pending), .checked(checked), .hits(hits)
   );

   always #4 clock = ~clock;

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.start_x = '0; req_ch.start_y = '0; req_ch.start_z = '0;
      req_ch.end_x   = '0; req_ch.end_y   = '0; req_ch.end_z   = '0;
      rsp_ch.ready   = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("timeout");
      $display("end of test: mismatches");
      $finish;
   end

   // result side back-pressure
   initial begin
      @(negedge reset);
      forever begin
         rsp_ch.ready <= 1'b1;
         if (quiet) begin
            @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   function automatic int q(int units);
      return units <<< FRAC;
   endfunction

   function automatic int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return int'(v);
   endfunction

   function automatic int rand_coord(int ax);
      longint span, r;
      case ($urandom_range(0, 7))
         0, 1: return $urandom;
         2:    return clamp32(box_c[ax] - box_h[ax]);
         3:    return clamp32(box_c[ax] + box_h[ax]);
         default: begin
            span = 4 * box_h[ax] + 4 * ONE + 1;
            r = longint'({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF) % span;
            return clamp32(box_c[ax] + r - 2 * box_h[ax] - 2 * ONE);
         end
      endcase
   endfunction

   task automatic send_seg(input int sx, sy, sz, ex, ey, ez);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.start_x <= sx; req_ch.start_y <= sy; req_ch.start_z <= sz;
      req_ch.end_x   <= ex; req_ch.end_y   <= ey; req_ch.end_z   <= ez;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      int s [3];
      int e [3];
      repeat (count) begin
         for (int k = 0; k < 3; k++) begin
            s[k] = rand_coord(k);
            e[k] = ($urandom_range(0, 7) == 0) ? s[k] : rand_coord(k);
         end
         send_seg(s[0], s[1], s[2], e[0], e[1], e[2]);
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic set_box(input int cx, cy, cz, input int hx, hy, hz);
      int vals [6];
      vals = '{cx, cy, cz, hx, hy, hz};
      drain();
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
      box_c = '{longint'(cx), longint'(cy), longint'(cz)};
      box_h = '{longint'(hx) & 32'h3FFF_FFFF, longint'(hy) & 32'h3FFF_FFFF,
                longint'(hz) & 32'h3FFF_FFFF};
   endtask

   task automatic random_box();
      set_box(q($urandom_range(0, 2000)) - q(1000), q($urandom_range(0, 2000)) - q(1000),
              q($urandom_range(0, 2000)) - q(1000), $urandom_range(1, 50 << FRAC),
              $urandom_range(1, 50 << FRAC), $urandom_range(1, 50 << FRAC));
   endtask

   localparam int MN = 32'h8000_0000;
   localparam int MX = 32'h7FFF_FFFF;

   initial begin
      box_c = '{0, 0, 0};
      box_h = '{0, 0, 0};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // degenerate box at the origin straight out of reset
      send_seg(-q(1), 0, 0, q(1), 0, 0);
      send_seg(0, 0, 0, q(2), q(3), q(4));
      send_seg(-q(1), q(1), 0, q(1), q(1), 0);

      set_box(0, 0, 0, q(10), q(10), q(10));
      send_seg(-q(20), 0, 0, q(20), 0, 0);
      send_seg(q(20), 0, 0, -q(20), 0, 0);
      send_seg(q(1), q(2), q(3), q(2), q(3), q(4));
      send_seg(0, 0, 0, q(20), q(5), 0);
      send_seg(q(1), q(1), q(1), q(1), q(1), q(1));
      send_seg(q(30), q(1), q(1), q(30), q(1), q(1));
      send_seg(-q(20), q(20), 0, q(20), q(20), 0);
      send_seg(-q(20), q(10), q(10), q(20), q(10), q(10));
      send_seg(-q(20), -q(20), -q(20), q(20), q(20), q(20));
      send_seg(-q(20), 0, 0, -q(10), 0, 0);
      send_seg(MN, MN, MN, MX, MX, MX);
      send_seg(MX, 0, MN, MN, 0, MX);
      send_seg(MN, MN, MN, MN, MN, MN);
      send_seg(MN, MX, 0, MX, MN, 0);
      send_seg(-1, 0, 0, 1, 0, 0);
      send_random(40);

      random_box();
      send_random(90);

      set_box(MX, MX, MX, 32'h3FFF_FFFF, 32'h3FFF_FFFF, 32'h3FFF_FFFF);
      send_seg(MN, MN, MN, MX, MX, MX);
      send_random(40);

      set_box(MN, MN, MN, 32'h3FFF_FFFF, 32'h3FFF_FFFF, 32'h3FFF_FFFF);
      send_seg(MX, MX, MX, MN, MN, MN);
      send_random(40);

      set_box(q(5), -q(7), q(3), 0, q(4), 32'hFFFF_FFFF);
      send_random(50);

      random_box();
      quiet <= 1'b1;
      send_random(120);

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d segment tests across seven box settings, %0d of them hits",
               checked, hits);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
